// ===== rtl/power_channel_switch_scheduler_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the power channel switch scheduler
// Clocked, reset-gated property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef POWER_CHANNEL_SWITCH_SCHEDULER_TOP_ASSERT_SVH
`define POWER_CHANNEL_SWITCH_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication on clk_i, disabled in reset.
`define PCSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk_i, disabled in reset.
`define PCSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pcss_pkg.sv =====
// ----------------------------------------------------------------------------
// pcss_pkg
// Shared types and codes of the power channel switch scheduler.
// ----------------------------------------------------------------------------
package pcss_pkg;

  localparam int Channels = 12;

  typedef enum logic [1:0] {
    FuncCtrl  = 2'd0,
    FuncQuery = 2'd1,
    FuncTick  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    OpOff       = 3'd0,
    OpOn        = 3'd1,
    OpToggle    = 3'd2,
    OpSchedOff  = 3'd3,
    OpSchedOn   = 3'd4,
    OpSchedClr  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    KindCtrl    = 2'd0,
    KindQuery   = 2'd1,
    KindFired   = 2'd2,
    KindUnknown = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CfgChannelCount = 2'd0,
    CfgUpdatePeriod = 2'd1
  } cfg_reg_e;

  localparam logic [15:0] UpdatePeriodReset = 16'd10;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  channel;
    logic [2:0]  op;
    logic [15:0] delay;
  } req_t;

  typedef struct packed {
    logic [3:0] chan_index;
    logic       is_on;
    logic [1:0] kind;
    logic       last;
  } rsp_t;

  // One channel's state word as held in the channel memory.
  typedef struct packed {
    logic        on;
    logic        pend;
    logic        toff;
    logic        ton;
    logic [15:0] limit;
    logic [15:0] elapsed;
  } entry_t;

endpackage

// ===== rtl/power_channel_switch_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// power_channel_switch_scheduler_top
// On/off switch control with delayed schedules for up to CHANNELS channels.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_i and raise start; a transaction is taken on a
//   rising edge with start high and busy low. Results come on result_o, each
//   for one cycle under result_valid_o; result_o.last marks the final one.
//   The receiver cannot stall, so every result is taken as it is shown.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i,
//   always ready; write only while the block is idle.
// Sequencing (one memory read port, one entry per cycle):
//   unknown channel: result in the cycle after accept, busy never rises.
//   control: read, modify, write; result registered out of S_CTRL, busy in S_CTRL.
//   query: n = active count entries swept, one result each; busy during the
//     sweep.
//   tick: all CHANNELS entries swept to age their timers, then the S_FLUSH
//     state for the held final result; busy until S_FLUSH ends.
// Reset: all channels read as on with no schedule (per-entry valid bits),
//   channel count 0, evaluation period 10, period counter 0. No clearing pass.
// ----------------------------------------------------------------------------
module power_channel_switch_scheduler_top #(
  parameter int CHANNELS = pcss_pkg::Channels
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  pcss_pkg::req_t req_i,
  output logic           result_valid_o,
  output pcss_pkg::rsp_t result_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [15:0]    cfg_data_i
);

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CntW = $clog2(CHANNELS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CHANNELS - 1);
  localparam pcss_pkg::entry_t ResetEntry = '{on: 1'b1, pend: 1'b0, toff: 1'b0,
                                              ton: 1'b0, limit: 16'd0,
                                              elapsed: 16'd0};

  typedef enum logic [2:0] {
    S_IDLE,
    S_CTRL,
    S_QUERY,
    S_TICK,
    S_FLUSH
  } state_e;

  state_e            state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  pcss_pkg::req_t    req_q, req_d;
  logic              eval_q, eval_d;
  logic [15:0]       pc_q, pc_d;
  logic [3:0]        count_q;
  logic [15:0]       period_q;
  logic              hold_valid_q, hold_valid_d;
  pcss_pkg::rsp_t    hold_q, hold_d;
  logic              rsp_valid_q, rsp_valid_d;
  pcss_pkg::rsp_t    rsp_q, rsp_d;
  logic [CHANNELS-1:0] vld_q;
  logic              rd_vld_q;

  // Channel memory: one read port, one write port, registered read data.
  pcss_pkg::entry_t  mem [CHANNELS];
  pcss_pkg::entry_t  rd_data_q;
  logic              rd_en, wr_en;
  logic [IdxW-1:0]   rd_addr, wr_addr;
  pcss_pkg::entry_t  wr_data;

  pcss_pkg::entry_t  cur, upd;
  logic [CntW-1:0]   n_act;
  logic [CntW-1:0]   idx_ext;
  logic              idx_last;
  logic              accept;
  logic [15:0]       pc_inc;
  logic              fire;

  assign accept      = start && (state_q == S_IDLE);
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign result_valid_o = rsp_valid_q;
  assign result_o       = rsp_q;

  // Clamp the configured count to the number of channels built.
  assign n_act = (5'(count_q) > 5'(CHANNELS)) ? CntW'(CHANNELS) : CntW'(count_q);
  assign idx_ext  = CntW'(idx_q);
  assign idx_last = (CntW'(idx_ext + CntW'(1)) == n_act);
  // Never-written entries read as the reset state.
  assign cur    = rd_vld_q ? rd_data_q : ResetEntry;
  assign pc_inc = (pc_q == 16'hFFFF) ? pc_q : pc_q + 16'd1;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    req_d        = req_q;
    eval_d       = eval_q;
    pc_d         = pc_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    rsp_valid_d  = 1'b0;
    rsp_d        = rsp_q;
    rd_en        = 1'b0;
    rd_addr      = idx_q + IdxW'(1);
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    upd          = cur;
    wr_data      = cur;
    fire         = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = req_i;
          case (req_i.func)
            pcss_pkg::FuncCtrl: begin
              if (5'(req_i.channel) >= 5'(n_act)) begin
                // Unknown channel: answer at once, touch nothing.
                rsp_valid_d = 1'b1;
                rsp_d = '{chan_index: req_i.channel, is_on: 1'b0,
                          kind: pcss_pkg::KindUnknown, last: 1'b1};
              end else begin
                rd_en   = 1'b1;
                rd_addr = req_i.channel[IdxW-1:0];
                state_d = S_CTRL;
              end
            end
            pcss_pkg::FuncQuery: begin
              if (n_act != '0) begin
                rd_en   = 1'b1;
                rd_addr = '0;
                idx_d   = '0;
                state_d = S_QUERY;
              end
            end
            pcss_pkg::FuncTick: begin
              eval_d       = (pc_inc >= period_q);
              pc_d         = (pc_inc >= period_q) ? 16'd0 : pc_inc;
              rd_en        = 1'b1;
              rd_addr      = '0;
              idx_d        = '0;
              hold_valid_d = 1'b0;
              state_d      = S_TICK;
            end
            default: ;
          endcase
        end
      end

      S_CTRL: begin
        case (req_q.op)
          pcss_pkg::OpOff:    upd.on = 1'b0;
          pcss_pkg::OpOn:     upd.on = 1'b1;
          pcss_pkg::OpToggle: upd.on = ~cur.on;
          pcss_pkg::OpSchedOff, pcss_pkg::OpSchedOn: begin
            upd.pend    = 1'b1;
            upd.ton     = (req_q.op == pcss_pkg::OpSchedOn);
            upd.toff    = (req_q.op == pcss_pkg::OpSchedOff);
            upd.limit   = req_q.delay;
            upd.elapsed = 16'd0;
          end
          pcss_pkg::OpSchedClr: begin
            upd.pend = 1'b0;
            upd.toff = 1'b0;
            upd.ton  = 1'b0;
          end
          default: ;
        endcase
        wr_en       = 1'b1;
        wr_addr     = req_q.channel[IdxW-1:0];
        wr_data     = upd;
        rsp_valid_d = 1'b1;
        rsp_d = '{chan_index: req_q.channel, is_on: upd.on,
                  kind: pcss_pkg::KindCtrl, last: 1'b1};
        state_d = S_IDLE;
      end

      S_QUERY: begin
        rsp_valid_d = 1'b1;
        rsp_d = '{chan_index: 4'(idx_q), is_on: cur.on,
                  kind: pcss_pkg::KindQuery, last: idx_last};
        if (idx_last) begin
          state_d = S_IDLE;
        end else begin
          rd_en = 1'b1;
          idx_d = idx_q + IdxW'(1);
        end
      end

      S_TICK: begin
        // Age every timer; fire only on an evaluation tick within the count.
        upd.elapsed = (cur.elapsed == 16'hFFFF) ? cur.elapsed : cur.elapsed + 16'd1;
        fire = eval_q && (idx_ext < n_act) && cur.pend && (upd.elapsed >= cur.limit);
        if (fire) begin
          if (cur.toff) begin
            upd.on = 1'b0;
          end else if (cur.ton) begin
            upd.on = 1'b1;
          end
          upd.pend = 1'b0;
          upd.toff = 1'b0;
          upd.ton  = 1'b0;
          // Release the previous fired result; it is not the final one.
          if (hold_valid_q) begin
            rsp_valid_d = 1'b1;
            rsp_d       = hold_q;
          end
          hold_valid_d = 1'b1;
          hold_d = '{chan_index: 4'(idx_q), is_on: upd.on,
                     kind: pcss_pkg::KindFired, last: 1'b0};
        end
        wr_en   = 1'b1;
        wr_data = upd;
        if (idx_q == LastIdx) begin
          state_d = S_FLUSH;
        end else begin
          rd_en = 1'b1;
          idx_d = idx_q + IdxW'(1);
        end
      end

      S_FLUSH: begin
        if (hold_valid_q) begin
          rsp_valid_d = 1'b1;
          rsp_d       = hold_q;
          rsp_d.last  = 1'b1;
        end
        hold_valid_d = 1'b0;
        state_d      = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      req_q        <= '0;
      eval_q       <= 1'b0;
      pc_q         <= 16'd0;
      count_q      <= 4'd0;
      period_q     <= pcss_pkg::UpdatePeriodReset;
      hold_valid_q <= 1'b0;
      hold_q       <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_q        <= '0;
      vld_q        <= '0;
      rd_vld_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      req_q        <= req_d;
      eval_q       <= eval_d;
      pc_q         <= pc_d;
      hold_valid_q <= hold_valid_d;
      hold_q       <= hold_d;
      rsp_valid_q  <= rsp_valid_d;
      rsp_q        <= rsp_d;
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          pcss_pkg::CfgChannelCount: count_q  <= cfg_data_i[3:0];
          pcss_pkg::CfgUpdatePeriod: period_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/pcss_checker.sv =====
// ----------------------------------------------------------------------------
// pcss_checker
// Port-level checks of the power channel switch scheduler, bound to the top.
// ----------------------------------------------------------------------------
`include "power_channel_switch_scheduler_top_assert.svh"

module pcss_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           busy_i,
  input logic           result_valid_i,
  input pcss_pkg::rsp_t result_i
);

  logic       non_final;
  logic       unknown_rsp;
  logic       ctrl_rsp;
  logic       query_rsp;
  logic       query_more;
  logic       idx_ok;
  logic [3:0] want_idx_q;

  assign non_final   = result_valid_i && !result_i.last;
  assign unknown_rsp = result_valid_i && (result_i.kind == pcss_pkg::KindUnknown);
  assign ctrl_rsp    = result_valid_i && (result_i.kind == pcss_pkg::KindCtrl);
  assign query_rsp   = result_valid_i && (result_i.kind == pcss_pkg::KindQuery);
  assign query_more  = query_rsp && !result_i.last;
  assign idx_ok      = (result_i.chan_index == want_idx_q);

  // Index that a following query result must carry.
  always_ff @(posedge clk_i) begin
    want_idx_q <= 4'(result_i.chan_index + 4'd1);
  end

  // More results follow a non-final one, so the block stays occupied.
  `PCSS_ASSERT_IMPL(a_more_busy, non_final, busy_i, "non-final result while idle")

  // Unknown-channel replies report off and end the transaction.
  `PCSS_ASSERT_IMPL(a_unknown, unknown_rsp, !result_i.is_on && result_i.last, "bad unknown reply")

  // Control replies are single results.
  `PCSS_ASSERT_IMPL(a_ctrl_last, ctrl_rsp, result_i.last, "control reply not final")

  // Query replies stream back to back in ascending channel order.
  `PCSS_ASSERT_NEXT(a_query_seq, query_more, query_rsp && idx_ok, "query stream broken")

endmodule

bind power_channel_switch_scheduler_top pcss_checker u_pcss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy_i         (busy),
  .result_valid_i (result_valid_o),
  .result_i       (result_o)
);
